FILE: src/fte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fte_pkg;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] ERA5_DAY      = 17'd8095;
	localparam logic [17:0] ERA4_DOE_OFS  = 18'd138002;
	localparam logic [17:0] DAYS_PER_ERA1 = 18'd146096;
	localparam logic [17:0] DAYS_PER_CENT = 18'd36524;

	localparam int unsigned HOUR_SHIFT = 29;
	localparam logic [17:0] HOUR_MUL   = 18'((2**29 + 3599) / 3600);
	localparam int unsigned MIN_SHIFT  = 18;
	localparam logic [12:0] MIN_MUL    = 13'((2**18 + 59) / 60);
	localparam int unsigned Q4Y_SHIFT  = 28;
	localparam logic [17:0] Q4Y_MUL    = 18'((2**28 + 1459) / 1460);
	localparam int unsigned YEAR_SHIFT = 26;
	localparam logic [17:0] YEAR_MUL   = 18'((2**26 + 364) / 365);
	localparam int unsigned MP_SHIFT   = 19;
	localparam logic [11:0] MP_MUL     = 12'((2**19 + 152) / 153);

	localparam logic [11:0] YEAR_LO = 12'd1980;
	localparam logic [11:0] YEAR_HI = 12'd2107;

	localparam logic [15:0] DATE_MIN = 16'h0021;
	localparam logic [15:0] TIME_MIN = 16'h0000;
	localparam logic [15:0] DATE_MAX = 16'hFF9F;
	localparam logic [15:0] TIME_MAX = 16'hBF7D;

	typedef struct packed {
		logic [15:0] fat_time;
		logic [15:0] fat_date;
	} fat_word_t;

	// day of March-based year at which each month starts
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] ofs;
		case (mp)
			4'd0:    ofs = 9'd0;
			4'd1:    ofs = 9'd31;
			4'd2:    ofs = 9'd61;
			4'd3:    ofs = 9'd92;
			4'd4:    ofs = 9'd122;
			4'd5:    ofs = 9'd153;
			4'd6:    ofs = 9'd184;
			4'd7:    ofs = 9'd214;
			4'd8:    ofs = 9'd245;
			4'd9:    ofs = 9'd275;
			4'd10:   ofs = 9'd306;
			4'd11:   ofs = 9'd337;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

endpackage

`default_nettype wire

FILE: src/fat_timestamp_encode.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts a day/minute/tick timestamp (days since 1978-01-01) into FAT date
// and time words. Fully pipelined: one transfer per clock while the output
// is not stalled, constant divisions done as reciprocal multiplies in
// separate stages. The whole pipeline holds while m_tready is low and a
// result waits. Seconds are rounded down to even and then advanced by two.
// Years outside 1980..2107 clamp to the nearest valid stamp with m_tuser set.
// TICK_RATE may be 1..68.
module fat_timestamp_encode #(
	parameter int unsigned TICK_RATE = 50
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // day_count[15:0], minute_of_day[10:0], tick_in_minute[11:0], pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // fat_date[15:0], fat_time[15:0]
	output logic             m_tuser   // out_of_range
);

	localparam int unsigned TICK_SHIFT = 24;
	localparam logic [24:0] TICK_MUL   = 25'((2**24 + TICK_RATE - 1) / TICK_RATE);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;

	// stage 1: ticks to seconds
	logic [36:0] tick_prod;
	logic [15:0] day_s1;
	logic [10:0] min_s1;
	logic [11:0] sec_s1;

	// stage 2: seconds of day, even plus two
	logic [16:0] sum_raw;
	logic [15:0] day_s2;
	logic [16:0] sod_s2;

	// stage 3: wrap into next day
	logic [16:0] day_s3;
	logic [16:0] sod_s3;

	// stage 4: era and day of era, hour
	logic [34:0] hour_prod;
	logic        era5_s4;
	logic [17:0] doe_s4;
	logic [16:0] sod_s4;
	logic [4:0]  hour_s4;

	// stage 5
	logic [35:0] q4y_prod;
	logic [16:0] rem_full;
	logic        era5_s5;
	logic [17:0] doe_s5;
	logic [6:0]  q4y_s5;
	logic [4:0]  hour_s5;
	logic [11:0] rem_s5;

	// stage 6
	logic [24:0] min_prod;
	logic [2:0]  cent_cnt;
	logic        era_end;
	logic        era5_s6;
	logic [17:0] doe_s6;
	logic [17:0] n_s6;
	logic [4:0]  hour_s6;
	logic [11:0] rem_s6;
	logic [5:0]  mn_s6;

	// stage 7
	logic [35:0] yoe_prod;
	logic [11:0] sec_full;
	logic        era5_s7;
	logic [17:0] doe_s7;
	logic [8:0]  yoe_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  mn_s7;
	logic [5:0]  sc_s7;

	// stage 8
	logic [1:0]  c100;
	logic [17:0] doy_full;
	logic [8:0]  doy_s8;
	logic [11:0] y_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  mn_s8;
	logic [5:0]  sc_s8;

	// stage 9
	logic [10:0] mp_arg;
	logic [22:0] mp_prod;
	logic [8:0]  doy_s9;
	logic [3:0]  mp_s9;
	logic [11:0] y_s9;
	logic [4:0]  hour_s9;
	logic [5:0]  mn_s9;
	logic [5:0]  sc_s9;

	// stage 10
	logic [8:0]  dy_full;
	logic [3:0]  mo_nxt;
	logic [11:0] yr_s10;
	logic [3:0]  mo_s10;
	logic [4:0]  dy_s10;
	logic [4:0]  hour_s10;
	logic [5:0]  mn_s10;
	logic [5:0]  sc_s10;

	// stage 11: clamp and pack
	logic [11:0]        yr_ofs;
	fte_pkg::fat_word_t res_nxt;
	logic               oor_nxt;
	fte_pkg::fat_word_t res_s11;
	logic               oor_s11;

	assign adv      = !vld_s11 || m_tready;
	assign s_tready = adv;

	assign tick_prod = 37'(s_tdata[38:27]) * 37'(TICK_MUL);
	assign sum_raw   = 17'(min_s1) * 17'd60 + 17'(sec_s1);
	assign hour_prod = 35'(sod_s3 >= fte_pkg::SECS_PER_DAY ?
		sod_s3 - fte_pkg::SECS_PER_DAY : sod_s3) * 35'(fte_pkg::HOUR_MUL);
	assign q4y_prod  = 36'(doe_s4) * 36'(fte_pkg::Q4Y_MUL);
	assign rem_full  = sod_s4 - 17'(hour_s4) * 17'd3600;
	assign min_prod  = 25'(rem_s5) * 25'(fte_pkg::MIN_MUL);
	assign cent_cnt  = 3'(doe_s5 >= fte_pkg::DAYS_PER_CENT)
		+ 3'(doe_s5 >= 18'(2 * 36524))
		+ 3'(doe_s5 >= 18'(3 * 36524))
		+ 3'(doe_s5 >= 18'(4 * 36524));
	assign era_end   = doe_s5 >= fte_pkg::DAYS_PER_ERA1;
	assign yoe_prod  = 36'(n_s6) * 36'(fte_pkg::YEAR_MUL);
	assign sec_full  = rem_s6 - 12'(mn_s6) * 12'd60;
	assign c100      = 2'(yoe_s7 >= 9'd100) + 2'(yoe_s7 >= 9'd200) + 2'(yoe_s7 >= 9'd300);
	assign doy_full  = doe_s7 - (18'(yoe_s7) * 18'd365 + 18'(yoe_s7[8:2]) - 18'(c100));
	assign mp_arg    = {doy_s8, 2'b00} + 11'(doy_s8) + 11'd2;
	assign mp_prod   = 23'(mp_arg) * 23'(fte_pkg::MP_MUL);
	assign dy_full   = doy_s9 - fte_pkg::month_offset(mp_s9) + 9'd1;
	assign mo_nxt    = (mp_s9 < 4'd10) ? mp_s9 + 4'd3 : mp_s9 - 4'd9;
	assign yr_ofs    = yr_s10 - fte_pkg::YEAR_LO;

	always_comb begin
		if (yr_s10 < fte_pkg::YEAR_LO) begin
			res_nxt.fat_date = fte_pkg::DATE_MIN;
			res_nxt.fat_time = fte_pkg::TIME_MIN;
			oor_nxt          = 1'b1;
		end else if (yr_s10 > fte_pkg::YEAR_HI) begin
			res_nxt.fat_date = fte_pkg::DATE_MAX;
			res_nxt.fat_time = fte_pkg::TIME_MAX;
			oor_nxt          = 1'b1;
		end else begin
			res_nxt.fat_date = {yr_ofs[6:0], mo_s10, dy_s10};
			res_nxt.fat_time = {hour_s10, mn_s10, sc_s10[5:1]};
			oor_nxt          = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			day_s1 <= s_tdata[15:0];
			min_s1 <= s_tdata[26:16];
			sec_s1 <= tick_prod[TICK_SHIFT+11:TICK_SHIFT];

			day_s2 <= day_s1;
			sod_s2 <= {sum_raw[16:1], 1'b0} + 17'd2;

			if (sod_s2 >= fte_pkg::SECS_PER_DAY) begin
				day_s3 <= 17'(day_s2) + 17'd1;
			end else begin
				day_s3 <= 17'(day_s2);
			end
			sod_s3 <= sod_s2;

			era5_s4 <= day_s3 >= fte_pkg::ERA5_DAY;
			if (day_s3 >= fte_pkg::ERA5_DAY) begin
				doe_s4 <= 18'(day_s3 - fte_pkg::ERA5_DAY);
			end else begin
				doe_s4 <= 18'(day_s3) + fte_pkg::ERA4_DOE_OFS;
			end
			sod_s4  <= (sod_s3 >= fte_pkg::SECS_PER_DAY) ? sod_s3 - fte_pkg::SECS_PER_DAY : sod_s3;
			hour_s4 <= hour_prod[fte_pkg::HOUR_SHIFT+4:fte_pkg::HOUR_SHIFT];

			era5_s5 <= era5_s4;
			doe_s5  <= doe_s4;
			q4y_s5  <= q4y_prod[fte_pkg::Q4Y_SHIFT+6:fte_pkg::Q4Y_SHIFT];
			hour_s5 <= hour_s4;
			rem_s5  <= rem_full[11:0];

			era5_s6 <= era5_s5;
			doe_s6  <= doe_s5;
			n_s6    <= doe_s5 - 18'(q4y_s5) + 18'(cent_cnt) - 18'(era_end);
			hour_s6 <= hour_s5;
			rem_s6  <= rem_s5;
			mn_s6   <= min_prod[fte_pkg::MIN_SHIFT+5:fte_pkg::MIN_SHIFT];

			era5_s7 <= era5_s6;
			doe_s7  <= doe_s6;
			yoe_s7  <= yoe_prod[fte_pkg::YEAR_SHIFT+8:fte_pkg::YEAR_SHIFT];
			hour_s7 <= hour_s6;
			mn_s7   <= mn_s6;
			sc_s7   <= sec_full[5:0];

			doy_s8  <= doy_full[8:0];
			y_s8    <= (era5_s7 ? 12'd2000 : 12'd1600) + 12'(yoe_s7);
			hour_s8 <= hour_s7;
			mn_s8   <= mn_s7;
			sc_s8   <= sc_s7;

			doy_s9  <= doy_s8;
			mp_s9   <= mp_prod[fte_pkg::MP_SHIFT+3:fte_pkg::MP_SHIFT];
			y_s9    <= y_s8;
			hour_s9 <= hour_s8;
			mn_s9   <= mn_s8;
			sc_s9   <= sc_s8;

			yr_s10   <= y_s9 + 12'(mo_nxt <= 4'd2);
			mo_s10   <= mo_nxt;
			dy_s10   <= dy_full[4:0];
			hour_s10 <= hour_s9;
			mn_s10   <= mn_s9;
			sc_s10   <= sc_s9;

			res_s11 <= res_nxt;
			oor_s11 <= oor_nxt;
		end
	end

	assign m_tvalid = vld_s11;
	assign m_tdata  = {res_s11.fat_time, res_s11.fat_date};
	assign m_tuser  = oor_s11;

	a_sod_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> sod_s4 < fte_pkg::SECS_PER_DAY)
		else $error("seconds of day not below one day");

	a_clamp_words: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[15:0] == fte_pkg::DATE_MIN ||
			m_tdata[15:0] == fte_pkg::DATE_MAX))
		else $error("clamped result with unexpected date");

	a_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[8:5] >= 4'd1 && m_tdata[8:5] <= 4'd12 &&
			m_tdata[4:0] != 5'd0))
		else $error("month or day out of range");

	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[31:27] <= 5'd23 && m_tdata[26:21] <= 6'd59 &&
			m_tdata[20:16] <= 5'd29))
		else $error("time field out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s10 && m_tvalid && !m_tready) |=> vld_s10)
		else $error("pipeline stage lost during stall");

endmodule

`default_nettype wire
